// ----- hdl/etwa_pkg.sv -----
// Shared constants and helpers for the endpoint table with aging.
package etwa_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int ADDR_W      = 32;
    localparam int PORT_W      = 16;
    localparam int STAMP_W     = 32;
    localparam int ENTRY_W     = ADDR_W + PORT_W + STAMP_W;

    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 3;
    localparam int SLOT_W      = 4;
    localparam int LIVE_W      = 5;
    localparam int MAX_AGE_W   = 17;

    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [MAX_AGE_W-1:0] MAX_AGE_RST = MAX_AGE_W'(60);
    localparam logic [0:0]           REG_MAX_AGE = 1'b0;

    localparam logic [KIND_W-1:0] KIND_BEACON = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PRUNE  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_REFRESHED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TICK      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_PRUNE     = 3'd4;

    typedef struct packed {
        logic [ADDR_W-1:0]  address;
        logic [PORT_W-1:0]  port;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
        return SLOT_W'(idx);
    endfunction

    function automatic logic [LIVE_W-1:0] to_live(input logic [CNT_W-1:0] cnt);
        return LIVE_W'(cnt);
    endfunction

endpackage

// ----- hdl/endpoint_table_with_aging_core.sv -----
// Endpoint table with aging: beacon learning, seconds counter and prune of stale entries.
//
// Beacon and prune items walk the table through the single read port of the entry RAM, one
// slot per cycle; tick and unknown items skip the walk. The input is stalled while an item
// is in work; a finished result waits in the output register, and the block holds its
// commit until that register is free. Valid bits live in flip-flops and are cleared by
// reset, so the table is usable right after reset. max_age is written through the APB port
// at byte address 0 and should only be changed while the block is idle.
module endpoint_table_with_aging_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [etwa_pkg::KIND_W-1:0]         i_kind,
    input  logic [etwa_pkg::ADDR_W-1:0]         i_source_address,
    input  logic [etwa_pkg::PORT_W-1:0]         i_source_port,

    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [etwa_pkg::STATUS_W-1:0]       o_status,
    output logic [etwa_pkg::SLOT_W-1:0]         o_slot,
    output logic [etwa_pkg::LIVE_W-1:0]         o_live_entries,
    output logic [etwa_pkg::LIVE_W-1:0]         o_removed_count,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [etwa_pkg::PADDR_W-1:0]        paddr,
    input  logic [etwa_pkg::PDATA_W-1:0]        pwdata,
    output logic [etwa_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    localparam int IDX_W = etwa_pkg::IDX_W;
    localparam int CNT_W = etwa_pkg::CNT_W;

    logic [1:0]                          r_state, n_state;
    logic [etwa_pkg::TABLE_DEPTH-1:0]    r_valid, n_valid;
    logic [CNT_W-1:0]                    r_live, n_live;
    logic [etwa_pkg::STAMP_W-1:0]        r_time, n_time;
    logic [etwa_pkg::MAX_AGE_W-1:0]      r_max_age;

    logic [etwa_pkg::KIND_W-1:0]         r_kind;
    logic [etwa_pkg::ADDR_W-1:0]         r_addr;
    logic [etwa_pkg::PORT_W-1:0]         r_port;

    logic [IDX_W:0]                      r_rd_cnt, n_rd_cnt;
    logic                                r_cmp_vld, n_cmp_vld;
    logic [IDX_W-1:0]                    r_cmp_idx, n_cmp_idx;
    logic                                r_hit_found, n_hit_found;
    logic [IDX_W-1:0]                    r_hit_idx, n_hit_idx;
    logic                                r_free_found, n_free_found;
    logic [IDX_W-1:0]                    r_free_idx, n_free_idx;
    logic [CNT_W-1:0]                    r_removed, n_removed;

    logic                                r_out_vld, n_out_vld;
    logic [etwa_pkg::STATUS_W-1:0]       r_out_status, n_out_status;
    logic [etwa_pkg::SLOT_W-1:0]         r_out_slot, n_out_slot;
    logic [etwa_pkg::LIVE_W-1:0]         r_out_live, n_out_live;
    logic [etwa_pkg::LIVE_W-1:0]         r_out_removed, n_out_removed;

    logic                                w_accept;
    logic                                w_rd_en;
    logic                                w_wr_en;
    logic [IDX_W-1:0]                    w_wr_idx;
    etwa_pkg::t_entry                    w_wr_entry;
    etwa_pkg::t_entry                    w_rd_entry;
    logic [etwa_pkg::ENTRY_W-1:0]        w_rd_data;
    logic [etwa_pkg::STAMP_W-1:0]        w_age;
    logic                                w_expired;
    logic                                w_match;
    logic                                w_slot_valid;
    logic                                w_out_free;
    logic                                w_cfg_wr;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_vld || !i_out_stall;

    assign w_rd_en    = (r_state == S_SCAN) &&
                        (r_rd_cnt < (IDX_W + 1)'(etwa_pkg::TABLE_DEPTH));
    assign w_rd_entry = etwa_pkg::t_entry'(w_rd_data);
    assign w_age      = r_time - w_rd_entry.stamp;
    assign w_expired  = w_age > etwa_pkg::STAMP_W'(r_max_age);
    assign w_match    = (w_rd_entry.address == r_addr) && (w_rd_entry.port == r_port);
    assign w_slot_valid = r_valid[r_cmp_idx];

    etwa_ram #(
        .WIDTH(etwa_pkg::ENTRY_W),
        .DEPTH(etwa_pkg::TABLE_DEPTH)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_idx),
        .i_wr_data (w_wr_entry),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_rd_cnt[IDX_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        n_state       = r_state;
        n_valid       = r_valid;
        n_live        = r_live;
        n_time        = r_time;
        n_rd_cnt      = r_rd_cnt;
        n_cmp_vld     = w_rd_en;
        n_cmp_idx     = r_rd_cnt[IDX_W-1:0];
        n_hit_found   = r_hit_found;
        n_hit_idx     = r_hit_idx;
        n_free_found  = r_free_found;
        n_free_idx    = r_free_idx;
        n_removed     = r_removed;
        n_out_vld     = r_out_vld && i_out_stall;
        n_out_status  = r_out_status;
        n_out_slot    = r_out_slot;
        n_out_live    = r_out_live;
        n_out_removed = r_out_removed;
        w_wr_en       = 1'b0;
        w_wr_idx      = r_hit_idx;
        w_wr_entry    = '{address: r_addr, port: r_port, stamp: r_time};

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_rd_cnt     = '0;
                    n_hit_found  = 1'b0;
                    n_free_found = 1'b0;
                    n_removed    = '0;
                    if (i_kind == etwa_pkg::KIND_BEACON || i_kind == etwa_pkg::KIND_PRUNE) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (w_rd_en) begin
                    n_rd_cnt = r_rd_cnt + 1'b1;
                end
                if (r_cmp_vld) begin
                    if (r_kind == etwa_pkg::KIND_BEACON) begin
                        if (w_slot_valid) begin
                            if (!r_hit_found && w_match) begin
                                n_hit_found = 1'b1;
                                n_hit_idx   = r_cmp_idx;
                            end
                        end else if (!r_free_found) begin
                            n_free_found = 1'b1;
                            n_free_idx   = r_cmp_idx;
                        end
                    end else if (w_slot_valid && w_expired) begin
                        n_valid[r_cmp_idx] = 1'b0;
                        n_removed          = r_removed + 1'b1;
                    end
                    if (r_cmp_idx == IDX_W'(etwa_pkg::TABLE_DEPTH - 1)) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_vld     = 1'b1;
                    n_out_slot    = '0;
                    n_out_removed = '0;
                    n_out_status  = etwa_pkg::ST_PRUNE;
                    case (r_kind)
                        etwa_pkg::KIND_BEACON: begin
                            if (r_hit_found) begin
                                w_wr_en      = 1'b1;
                                w_wr_idx     = r_hit_idx;
                                n_out_status = etwa_pkg::ST_REFRESHED;
                                n_out_slot   = etwa_pkg::to_slot(r_hit_idx);
                            end else if (r_free_found) begin
                                w_wr_en              = 1'b1;
                                w_wr_idx             = r_free_idx;
                                n_valid[r_free_idx]  = 1'b1;
                                n_live               = r_live + 1'b1;
                                n_out_status         = etwa_pkg::ST_ADDED;
                                n_out_slot           = etwa_pkg::to_slot(r_free_idx);
                            end else begin
                                n_out_status = etwa_pkg::ST_FULL;
                            end
                        end
                        etwa_pkg::KIND_TICK: begin
                            n_time       = r_time + 1'b1;
                            n_out_status = etwa_pkg::ST_TICK;
                        end
                        etwa_pkg::KIND_PRUNE: begin
                            n_live        = r_live - r_removed;
                            n_out_removed = etwa_pkg::to_live(r_removed);
                        end
                        default: begin
                            n_out_status = etwa_pkg::ST_PRUNE;
                        end
                    endcase
                    n_out_live = etwa_pkg::to_live(n_live);
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_live    <= '0;
            r_time    <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_live    <= n_live;
            r_time    <= n_time;
            r_cmp_vld <= n_cmp_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= i_kind;
            r_addr <= i_source_address;
            r_port <= i_source_port;
        end
        r_rd_cnt      <= n_rd_cnt;
        r_cmp_idx     <= n_cmp_idx;
        r_hit_found   <= n_hit_found;
        r_hit_idx     <= n_hit_idx;
        r_free_found  <= n_free_found;
        r_free_idx    <= n_free_idx;
        r_removed     <= n_removed;
        r_out_status  <= n_out_status;
        r_out_slot    <= n_out_slot;
        r_out_live    <= n_out_live;
        r_out_removed <= n_out_removed;
    end

    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_age <= etwa_pkg::MAX_AGE_RST;
        end else if (w_cfg_wr && paddr[2] == etwa_pkg::REG_MAX_AGE) begin
            r_max_age <= pwdata[etwa_pkg::MAX_AGE_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == etwa_pkg::REG_MAX_AGE) ?
                    etwa_pkg::PDATA_W'(r_max_age) : '0;

    assign o_out_valid     = r_out_vld;
    assign o_status        = r_out_status;
    assign o_slot          = r_out_slot;
    assign o_live_entries  = r_out_live;
    assign o_removed_count = r_out_removed;

    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= CNT_W'(etwa_pkg::TABLE_DEPTH))
        else $error("live count exceeds table depth");

    a_live_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_live == CNT_W'($countones(r_valid))))
        else $error("live count out of step with valid bits");

    a_no_compare_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_cmp_vld)
        else $error("compare stage busy while idle");

    a_full_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_status == etwa_pkg::ST_FULL) |->
        (r_out_live == etwa_pkg::LIVE_W'(etwa_pkg::TABLE_DEPTH)))
        else $error("table full reported with free slots");

    a_added_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && w_out_free && r_kind == etwa_pkg::KIND_BEACON &&
         !r_hit_found && r_free_found) |=> r_valid[$past(r_free_idx)])
        else $error("added entry not marked valid");

endmodule

// ----- hdl/etwa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module etwa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                         i_wr_data,
    input  logic                                     i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
